>>> rtl/core/cpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_pkg: shared types and codes of the clock page replacement block
// Request and response transfer formats, request codes, page temperature
// codes and the controller state type.
// ----------------------------------------------------------------------------
package cpr_pkg;

    // Request codes carried in the func field.
    localparam logic [2:0] FUNC_HIT   = 3'd0;
    localparam logic [2:0] FUNC_PIN   = 3'd1;
    localparam logic [2:0] FUNC_UNPIN = 3'd2;
    localparam logic [2:0] FUNC_CLAIM = 3'd3;
    localparam logic [2:0] FUNC_PEEK  = 3'd4;

    // Page temperature codes; the fourth code behaves as evicting.
    localparam logic [1:0] TEMP_COLD  = 2'd0;
    localparam logic [1:0] TEMP_HOT   = 2'd1;
    localparam logic [1:0] TEMP_EVICT = 2'd2;

    // Width of the page count register as seen on the configuration port.
    localparam int CFG_W  = 11;
    // Width of the page index fields in the transfers.
    localparam int PAGE_W = 10;

    typedef struct packed {
        logic [2:0]        func;
        logic [PAGE_W-1:0] page_index;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [PAGE_W-1:0] result_page;
        logic              pin_clamped;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

>>> rtl/core/clock_page_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_page_replacement: CLOCK (second chance) victim selector
// Keeps a temperature and a saturating pin count per page in one on-chip
// memory and serves hit, pin, unpin, victim claim and victim peek requests.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                       Dir  Transfer
//  --------  ----------------------------  ---  -------------------------------
//  request   req_valid, req_ready, req     in   valid & ready at rising edge
//  response  rsp_valid, rsp_ready, rsp     out  valid & ready at rising edge
//  config    cfg_we, cfg_wdata             in   cfg_we high at rising edge
//
// Hit, pin and unpin requests issue the memory read in the transfer cycle; the
// execute state then modifies the entry and writes it back unless a pin clamps.
// Unknown requests write nothing. A victim claim or peek visits one slot at a
// time as the hand advances, at most 2 * pages_in_use slots, since the single
// memory read port serves one read-modify-write at a time.
// After reset a clearing pass writes every one of the MAX_PAGES entries,
// one per cycle, during which no request is taken.
// The result lands in an output register, so a new request is taken while
// an older result waits; a request that finishes while that register is
// still full holds in place until the response transfer frees it.
//
module clock_page_replacement #(
    parameter int MAX_PAGES = 1024,
    parameter int PIN_BITS  = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  cpr_pkg::req_t                   req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output cpr_pkg::rsp_t                   rsp,
    input  logic                            cfg_we,
    input  logic [cpr_pkg::CFG_W-1:0]       cfg_wdata
);
    import cpr_pkg::*;

    // Width of a page address into the memory.
    localparam int IDX_W  = $clog2(MAX_PAGES);
    // Width that holds the page count itself, at least the port width.
    localparam int CNT_W  = ($clog2(MAX_PAGES + 1) > CFG_W) ? $clog2(MAX_PAGES + 1) : CFG_W;
    // The sweep counter has to reach twice the page count.
    localparam int SPIN_W = CNT_W + 1;
    localparam int WORD_W = PIN_BITS + 2;

    // Each memory word holds {temperature, pin count}.
    logic [WORD_W-1:0]  mem [MAX_PAGES];
    logic [WORD_W-1:0]  mem_q_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;

    // Write-to-read forwarding for a read issued in the cycle of a write
    // to the same entry (a sweep over a single page).
    logic               fwd_valid_reg;
    logic               fwd_valid_next;
    logic [WORD_W-1:0]  fwd_word_reg;

    state_t             state_reg;
    state_t             state_next;

    logic [CNT_W-1:0]   pages_reg;
    logic [CNT_W-1:0]   pages_next;
    logic [IDX_W-1:0]   hand_reg;
    logic [IDX_W-1:0]   hand_next;
    logic [SPIN_W-1:0]  spins_reg;
    logic [SPIN_W-1:0]  spins_next;
    logic [IDX_W-1:0]   clr_addr_reg;
    logic [IDX_W-1:0]   clr_addr_next;
    logic [2:0]         func_reg;
    logic [IDX_W-1:0]   cur_addr_reg;

    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_result;

    logic               req_xfer;
    logic               req_sweep;
    logic               exec_sweep;
    logic [PAGE_W-1:0]  page_rem;
    logic [IDX_W-1:0]   page_mod;
    logic [WORD_W-1:0]  word;
    logic [1:0]         temp;
    logic [PIN_BITS-1:0] pin;
    logic [CNT_W-1:0]   hand_inc;
    logic [IDX_W-1:0]   hand_wrap;
    logic [SPIN_W-1:0]  spin_inc;
    logic               finish;
    logic               out_free;
    logic               rsp_load;
    logic [CNT_W-1:0]   cfg_clamped;
    logic               clr_done;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_xfer  = req_valid && req_ready;
    assign req_sweep = (req.func == FUNC_CLAIM) || (req.func == FUNC_PEEK);
    assign exec_sweep = (func_reg == FUNC_CLAIM) || (func_reg == FUNC_PEEK);
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign clr_done  = (clr_addr_reg == IDX_W'(MAX_PAGES - 1));

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Page index reduced modulo MAX_PAGES by conditional subtraction of
    // shifted copies of the depth, widest first.
    always_comb
    begin
        page_rem = req.page_index;
        for (int k = PAGE_W - 1; k >= 0; k--)
        begin
            if ((MAX_PAGES << k) < (1 << PAGE_W))
            begin
                if (page_rem >= PAGE_W'(MAX_PAGES << k))
                begin
                    page_rem = page_rem - PAGE_W'(MAX_PAGES << k);
                end
            end
        end
    end
    assign page_mod = IDX_W'(page_rem);

    // A written page count of zero acts as one, anything above the depth
    // acts as the depth.
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cfg_clamped = CNT_W'(1);
        end
        else if (CNT_W'(cfg_wdata) > CNT_W'(MAX_PAGES))
        begin
            cfg_clamped = CNT_W'(MAX_PAGES);
        end
        else
        begin
            cfg_clamped = CNT_W'(cfg_wdata);
        end
    end

    // The entry under work, with the forwarded copy taking precedence.
    assign word = fwd_valid_reg ? fwd_word_reg : mem_q_reg;
    assign temp = word[WORD_W-1:PIN_BITS];
    assign pin  = word[PIN_BITS-1:0];

    // Hand advance with wrap at the page count.
    assign hand_inc  = CNT_W'(hand_reg) + CNT_W'(1);
    assign hand_wrap = (hand_inc == pages_reg) ? '0 : IDX_W'(hand_inc);
    assign spin_inc  = spins_reg + SPIN_W'(1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        mem_we        = 1'b0;
        mem_waddr     = cur_addr_reg;
        mem_wdata     = word;
        mem_raddr     = cur_addr_reg;
        finish        = 1'b0;
        rsp_result    = '0;
        hand_next     = hand_reg;
        spins_next    = spins_reg;
        clr_addr_next = clr_addr_reg;
        rsp_load      = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
            end
            ST_IDLE:
            begin
                mem_raddr  = req_sweep ? hand_reg : page_mod;
                spins_next = '0;
            end
            ST_EXEC:
            begin
                case (func_reg)
                    FUNC_HIT:
                    begin
                        finish    = 1'b1;
                        mem_we    = 1'b1;
                        mem_wdata = {TEMP_HOT, pin};
                    end
                    FUNC_PIN:
                    begin
                        finish = 1'b1;
                        if (pin == '1)
                        begin
                            rsp_result.pin_clamped = 1'b1;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {temp, pin + PIN_BITS'(1)};
                            if (pin == '0)
                            begin
                                rsp_result.found       = 1'b1;
                                rsp_result.result_page = PAGE_W'(cur_addr_reg);
                            end
                        end
                    end
                    FUNC_UNPIN:
                    begin
                        finish = 1'b1;
                        mem_we = 1'b1;
                        if (pin == '0)
                        begin
                            rsp_result.pin_clamped = 1'b1;
                            mem_wdata = {TEMP_HOT, pin};
                        end
                        else
                        begin
                            mem_wdata = {TEMP_HOT, pin - PIN_BITS'(1)};
                        end
                    end
                    FUNC_CLAIM, FUNC_PEEK:
                    begin
                        mem_waddr = hand_reg;
                        mem_raddr = hand_wrap;
                        hand_next = hand_wrap;
                        if ((temp == TEMP_COLD) && (pin == '0))
                        begin
                            finish                 = 1'b1;
                            rsp_result.found       = 1'b1;
                            rsp_result.result_page = PAGE_W'(hand_reg);
                            if (func_reg == FUNC_CLAIM)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = {TEMP_EVICT, PIN_BITS'(1)};
                            end
                        end
                        else
                        begin
                            if (temp == TEMP_HOT)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = {TEMP_COLD, pin};
                            end
                            spins_next = spin_inc;
                            if (spin_inc == {pages_reg, 1'b0})
                            begin
                                finish = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase

                // A finished request waits for the output register, redoing
                // the same slot next cycle without touching any state.
                if (finish && !out_free)
                begin
                    mem_we     = 1'b0;
                    hand_next  = hand_reg;
                    spins_next = spins_reg;
                    mem_raddr  = exec_sweep ? hand_reg : cur_addr_reg;
                end
                else
                begin
                    rsp_load = finish;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign fwd_valid_next = mem_we && (mem_waddr == mem_raddr);
    assign rsp_valid_next = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);
    assign pages_next     = cfg_we ? cfg_clamped : pages_reg;

    // Page state memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= mem[mem_raddr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pages_reg     <= CNT_W'(MAX_PAGES);
            hand_reg      <= '0;
            spins_reg     <= '0;
            clr_addr_reg  <= '0;
            fwd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pages_reg     <= pages_next;
            hand_reg      <= cfg_we ? '0 : hand_next;
            spins_reg     <= spins_next;
            clr_addr_reg  <= clr_addr_next;
            fwd_valid_reg <= fwd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        fwd_word_reg <= mem_wdata;
        if (req_xfer)
        begin
            func_reg     <= req.func;
            cur_addr_reg <= page_mod;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_result;
        end
    end

`ifndef SYNTHESIS
    // The hand always points inside the swept range.
    a_hand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(hand_reg) < pages_reg)
        else $error("clock hand outside the swept pages");

    // The page count stays between one and the memory depth.
    a_pages_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (pages_reg != '0) && (pages_reg <= CNT_W'(MAX_PAGES)))
        else $error("page count out of range");

    // A sweep never visits more than twice the page count.
    a_spins_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> (spins_reg < {pages_reg, 1'b0}))
        else $error("sweep ran past its slot limit");

    // The memory is written only by the clearing pass or a request at work.
    a_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != ST_IDLE))
        else $error("memory written while idle");

    // A result is loaded only into a free output register.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |-> (!rsp_valid_reg || rsp_ready))
        else $error("pending response overwritten");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the clock page replacement block
// A shadow copy of the page table follows every accepted request and works
// out the expected response. Responses are checked in order, field by field.
// Requests run first as a short directed list and then as random mixes over
// several page counts. In one of those phases a page's pin count is also driven
// to both of its limits.
// ----------------------------------------------------------------------------
module tb;
    import cpr_pkg::*;

    localparam int MAX_PAGES   = 1024;
    localparam int PIN_BITS    = 8;
    localparam int PIN_TOP     = (1 << PIN_BITS) - 1;
    localparam int CYCLE_LIMIT = 16_000_000;
    localparam int RANDOM_RUN  = 73;
    localparam int SATURATE_AT = 7;

    // Request codes the block does not know; they must leave no trace.
    localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

    // Page counts written between phases: extremes, out of range values and
    // small counts, so that sweeps wrap and give up often.
    localparam logic [CFG_W-1:0] PAGE_SETTINGS [12] = '{
        11'd1, 11'd0, 11'd2, 11'd2047, 11'd3, 11'd7,
        11'd1025, 11'd5, 11'd16, 11'd1024, 11'd33, 11'd4
    };

    // Shadow of the page table, the hand and the page count.
    class page_table_mirror;
        logic [1:0]  temperature [MAX_PAGES];
        int unsigned pin_count [MAX_PAGES];
        int unsigned pages_in_use;
        int unsigned hand;
        rsp_t        answers_due [$];
        int          mismatches;

        function new();
            pages_in_use = MAX_PAGES;
            hand         = 0;
            mismatches   = 0;
            foreach (temperature[i])
            begin
                temperature[i] = TEMP_COLD;
                pin_count[i]   = 0;
            end
        endfunction

        function void set_pages(logic [CFG_W-1:0] value);
            int unsigned v;
            v = value;
            if (v == 0)
                v = 1;
            if (v > MAX_PAGES)
                v = MAX_PAGES;
            pages_in_use = v;
            hand         = 0;
        endfunction

        // One pass of the hand; claim marks the victim, a peek leaves it alone.
        function bit sweep(bit claim, output logic [PAGE_W-1:0] victim);
            int unsigned spins;
            int unsigned s;
            int unsigned slot;
            victim = '0;
            spins  = 2 * pages_in_use;
            for (s = 0; s < spins; s++)
            begin
                slot = hand;
                hand = (slot + 1) % pages_in_use;
                if (temperature[slot] == TEMP_COLD)
                begin
                    if (pin_count[slot] == 0)
                    begin
                        if (claim)
                        begin
                            temperature[slot] = TEMP_EVICT;
                            pin_count[slot]   = 1;
                        end
                        victim = PAGE_W'(slot);
                        return 1'b1;
                    end
                end
                else if (temperature[slot] == TEMP_HOT)
                begin
                    temperature[slot] = TEMP_COLD;
                end
            end
            return 1'b0;
        endfunction

        function void apply_request(req_t r);
            rsp_t              answer;
            int unsigned       p;
            logic [PAGE_W-1:0] victim;
            answer = '0;
            p      = r.page_index % MAX_PAGES;
            case (r.func)
                FUNC_HIT:
                begin
                    temperature[p] = TEMP_HOT;
                end
                FUNC_PIN:
                begin
                    if (pin_count[p] >= PIN_TOP)
                    begin
                        pin_count[p]       = PIN_TOP;
                        answer.pin_clamped = 1'b1;
                    end
                    else
                    begin
                        if (pin_count[p] == 0)
                        begin
                            answer.found       = 1'b1;
                            answer.result_page = PAGE_W'(p);
                        end
                        pin_count[p]++;
                    end
                end
                FUNC_UNPIN:
                begin
                    if (pin_count[p] == 0)
                        answer.pin_clamped = 1'b1;
                    else
                        pin_count[p]--;
                    temperature[p] = TEMP_HOT;
                end
                FUNC_CLAIM, FUNC_PEEK:
                begin
                    if (sweep(r.func == FUNC_CLAIM, victim))
                    begin
                        answer.found       = 1'b1;
                        answer.result_page = victim;
                    end
                end
                default:
                begin
                end
            endcase
            answers_due.push_back(answer);
        endfunction

        function void compare_response(rsp_t got);
            rsp_t want;
            if (answers_due.size() == 0)
            begin
                $error("response with no request waiting: found=%0d result_page=%0d pin_clamped=%0d",
                       got.found, got.result_page, got.pin_clamped);
                mismatches++;
                return;
            end
            want = answers_due.pop_front();
            if (got.found !== want.found)
            begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                mismatches++;
            end
            if (got.result_page !== want.result_page)
            begin
                $error("result_page: expected %0d, actual %0d", want.result_page, got.result_page);
                mismatches++;
            end
            if (got.pin_clamped !== want.pin_clamped)
            begin
                $error("pin_clamped: expected %0d, actual %0d", want.pin_clamped, got.pin_clamped);
                mismatches++;
            end
        endfunction
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_ready;
    req_t             req       = '0;
    logic             rsp_valid;
    logic             rsp_ready = 1'b0;
    rsp_t             rsp;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // When set, that side runs without gaps for the current phase.
    bit               sender_calm   = 1'b0;
    bit               receiver_calm = 1'b0;
    int unsigned      cycles        = 0;

    page_table_mirror mirror = new();

    clock_page_replacement #(
        .MAX_PAGES(MAX_PAGES),
        .PIN_BITS (PIN_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #4 clk = ~clk;

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Response side: random stalls, checks each transfer as it happens.
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = receiver_calm ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (rsp_valid !== 1'b1) @(posedge clk);
            mirror.compare_response(rsp);
        end
    end

    // Valid stays up across back-to-back requests; it only drops for a gap.
    task automatic send_request(req_t r);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_ready !== 1'b1) @(posedge clk);
        mirror.apply_request(r);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (mirror.answers_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_pages(logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        mirror.set_pages(value);
    endtask

    function automatic req_t make_req(logic [2:0] f, int unsigned p);
        req_t r;
        r.func       = f;
        r.page_index = PAGE_W'(p);
        return r;
    endfunction

    // Mostly pages the hand can reach, now and then any page at all.
    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            r.func = FUNC_HIT;
        else if (pick < 35)
            r.func = FUNC_PIN;
        else if (pick < 52)
            r.func = FUNC_UNPIN;
        else if (pick < 77)
            r.func = FUNC_CLAIM;
        else if (pick < 93)
            r.func = FUNC_PEEK;
        else
            r.func = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
        if ($urandom_range(0, 9) < 8)
            r.page_index = PAGE_W'($urandom_range(0, mirror.pages_in_use - 1));
        else
            r.page_index = PAGE_W'($urandom_range(0, MAX_PAGES - 1));
        return r;
    endfunction

    task automatic random_phase();
        sender_calm   = ($urandom_range(0, 3) == 0);
        receiver_calm = ($urandom_range(0, 3) == 0);
        repeat (RANDOM_RUN) send_request(random_request());
    endtask

    initial
    begin
        int unsigned hot_page;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Directed requests at the reset page count; the table starts all cold.
        send_request(make_req(FUNC_PEEK, 0));
        send_request(make_req(FUNC_CLAIM, 0));
        send_request(make_req(FUNC_CLAIM, 1023));
        send_request(make_req(FUNC_HIT, 1023));
        send_request(make_req(FUNC_HIT, 0));
        send_request(make_req(FUNC_PIN, 3));
        send_request(make_req(FUNC_PIN, 3));
        // The hand now meets a cold page that is pinned and must pass it by.
        send_request(make_req(FUNC_CLAIM, 0));
        send_request(make_req(FUNC_UNPIN, 3));
        send_request(make_req(FUNC_UNPIN, 3));
        // Unpin below zero clamps but still marks the page hot.
        send_request(make_req(FUNC_UNPIN, 3));
        send_request(make_req(FUNC_UNPIN, 1));
        send_request(make_req(FUNC_PEEK, 1023));
        send_request(make_req(FUNC_PIN, 1023));
        send_request(make_req(FUNC_UNPIN, 1023));
        send_request(make_req(FUNC_UNUSED_LO, 1023));
        send_request(make_req(3'd6, 682));
        send_request(make_req(FUNC_UNUSED_HI, 1023));
        send_request(make_req(FUNC_CLAIM, 341));
        send_request(make_req(FUNC_HIT, 512));
        send_request(make_req(FUNC_PIN, 682));
        send_request(make_req(FUNC_UNPIN, 341));
        send_request(make_req(FUNC_PEEK, 0));

        random_phase();

        foreach (PAGE_SETTINGS[k])
        begin
            // The page count only changes once every response is back.
            drain();
            write_pages(PAGE_SETTINGS[k]);
            if (k == SATURATE_AT)
            begin
                // Walk one page's pin count past the top and back below zero.
                hot_page = $urandom_range(0, mirror.pages_in_use - 1);
                repeat (PIN_TOP + 3)
                begin
                    send_request(make_req(FUNC_PIN, hot_page));
                    if ($urandom_range(0, 7) == 0)
                        send_request(random_request());
                end
                repeat (PIN_TOP + 5)
                begin
                    send_request(make_req(FUNC_UNPIN, hot_page));
                    if ($urandom_range(0, 7) == 0)
                        send_request(random_request());
                end
            end
            random_phase();
        end

        drain();
        repeat (20) @(posedge clk);
        if (mirror.mismatches == 0 && mirror.answers_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
